// ===== src/line_pair_intersection_defines.svh =====
// Assertion macros for the line pair intersection block.
// Used by the top level; expects clk and rst in scope.
`ifndef LINE_PAIR_INTERSECTION_DEFINES_SVH
`define LINE_PAIR_INTERSECTION_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define LPI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define LPI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`define LPI_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);
`else
`define LPI_ASSERT_IMPL(lbl, ante, cons, msg)
`define LPI_ASSERT_NEXT(lbl, ante, cons, msg)
`define LPI_ASSERT_RST(lbl, cons, msg)
`endif

`endif

// ===== src/lpi_pkg.sv =====
// Shared types and constants for the line pair intersection block.
// No dependencies.
`timescale 1ns / 1ps
package lpi_pkg;
  localparam int OUT_BITS = 48;

  localparam logic [1:0] REL_POINT      = 2'd0;
  localparam logic [1:0] REL_COINCIDENT = 2'd1;
  localparam logic [1:0] REL_PARALLEL   = 2'd2;

  typedef struct packed {
    logic       valid;
    logic [1:0] rel;
    logic       neg_x;
    logic       neg_y;
  } lpi_ctl_t;
endpackage

// ===== src/lpi_front.sv =====
// Front pipeline: differences, cross products, relation, numerators, magnitudes.
// Depends on lpi_pkg.
`timescale 1ns / 1ps
module lpi_front import lpi_pkg::*; #(
  parameter int C  = 16,
  parameter int F  = 16,
  parameter int NB = 3 * C + 2 + F,
  parameter int DM = 2 * C + 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  logic signed [C-1:0] a1_x,
  input  logic signed [C-1:0] a1_y,
  input  logic signed [C-1:0] a2_x,
  input  logic signed [C-1:0] a2_y,
  input  logic signed [C-1:0] b1_x,
  input  logic signed [C-1:0] b1_y,
  input  logic signed [C-1:0] b2_x,
  input  logic signed [C-1:0] b2_y,
  output lpi_ctl_t            ctl_o,
  output logic [DM-1:0]       d_o,
  output logic [NB-1:0]       dvd_o [2]
);
  localparam int DF = C + 1;
  localparam int DW = 2 * C + 2;
  localparam int L  = C + 1;
  localparam int HW = DW - L;
  localparam int VW = 3 * C + 3;
  localparam int VM = VW - 1;

  // stage A
  logic v_a;
  logic signed [C-1:0]  a1x_a, a1y_a;
  logic signed [DF-1:0] dax_a, day_a, dbx_a, dby_a, tx_a, ty_a;
  // stage B
  logic v_b;
  logic signed [C-1:0]    a1x_b, a1y_b;
  logic signed [DF-1:0]   dax_b, day_b;
  logic signed [2*DF-1:0] pd0_b, pd1_b, pn0_b, pn1_b, pa0_b, pa1_b, pc0_b, pc1_b;
  // stage C
  logic v_c;
  logic [1:0]           rel_c;
  logic signed [C-1:0]  a1x_c, a1y_c;
  logic signed [DF-1:0] dax_c, day_c;
  logic signed [DW-1:0] den_c, num_c;
  // stage D
  logic v_d;
  logic [1:0]           rel_d;
  logic signed [DW-1:0] den_d;
  logic signed [C+L:0]      pbx_l, pby_l;
  logic signed [C+HW-1:0]   pbx_h, pby_h;
  logic signed [DF+L:0]     pnx_l, pny_l;
  logic signed [DF+HW-1:0]  pnx_h, pny_h;
  logic signed [L:0]    den_lo, num_lo;
  logic signed [HW-1:0] den_hi, num_hi;
  // stage E
  logic v_e;
  logic [1:0]           rel_e;
  logic                 dneg_e;
  logic [DM-1:0]        dmag_e;
  logic signed [VW-1:0] vx_e, vy_e;
  // stage F
  logic v_f;
  logic [1:0]    rel_f;
  logic          negx_f, negy_f;
  logic [DM-1:0] dmag_f;
  logic [NB-1:0] dx_f, dy_f;

  assign den_lo = {1'b0, den_c[L-1:0]};
  assign den_hi = den_c[DW-1:L];
  assign num_lo = {1'b0, num_c[L-1:0]};
  assign num_hi = num_c[DW-1:L];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
      v_d <= 1'b0;
      v_e <= 1'b0;
      v_f <= 1'b0;
    end else if (adv) begin
      v_a <= in_valid;
      v_b <= v_a;
      v_c <= v_b;
      v_d <= v_c;
      v_e <= v_d;
      v_f <= v_e;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1x_a <= a1_x;
      a1y_a <= a1_y;
      dax_a <= {a2_x[C-1], a2_x} - {a1_x[C-1], a1_x};
      day_a <= {a2_y[C-1], a2_y} - {a1_y[C-1], a1_y};
      dbx_a <= {b2_x[C-1], b2_x} - {b1_x[C-1], b1_x};
      dby_a <= {b2_y[C-1], b2_y} - {b1_y[C-1], b1_y};
      tx_a  <= {a1_x[C-1], a1_x} - {b1_x[C-1], b1_x};
      ty_a  <= {a1_y[C-1], a1_y} - {b1_y[C-1], b1_y};

      a1x_b <= a1x_a;
      a1y_b <= a1y_a;
      dax_b <= dax_a;
      day_b <= day_a;
      pd0_b <= dax_a * dby_a;
      pd1_b <= day_a * dbx_a;
      pn0_b <= dbx_a * ty_a;
      pn1_b <= dby_a * tx_a;
      pa0_b <= tx_a * day_a;
      pa1_b <= ty_a * dax_a;
      pc0_b <= tx_a * dby_a;
      pc1_b <= ty_a * dbx_a;

      a1x_c <= a1x_b;
      a1y_c <= a1y_b;
      dax_c <= dax_b;
      day_c <= day_b;
      den_c <= pd0_b - pd1_b;
      num_c <= pn0_b - pn1_b;
      if (pd0_b != pd1_b) begin
        rel_c <= REL_POINT;
      end else if (pa0_b == pa1_b && pc0_b == pc1_b) begin
        rel_c <= REL_COINCIDENT;
      end else begin
        rel_c <= REL_PARALLEL;
      end

      rel_d <= rel_c;
      den_d <= den_c;
      pbx_l <= a1x_c * den_lo;
      pbx_h <= a1x_c * den_hi;
      pby_l <= a1y_c * den_lo;
      pby_h <= a1y_c * den_hi;
      pnx_l <= dax_c * num_lo;
      pnx_h <= dax_c * num_hi;
      pny_l <= day_c * num_lo;
      pny_h <= day_c * num_hi;

      rel_e  <= rel_d;
      dneg_e <= den_d[DW-1];
      dmag_e <= den_d[DW-1] ? DM'(-den_d) : DM'(den_d);
      vx_e   <= (VW'(pbx_h) <<< L) + VW'(pbx_l) + (VW'(pnx_h) <<< L) + VW'(pnx_l);
      vy_e   <= (VW'(pby_h) <<< L) + VW'(pby_l) + (VW'(pny_h) <<< L) + VW'(pny_l);

      rel_f  <= rel_e;
      dmag_f <= dmag_e;
      negx_f <= vx_e[VW-1] ^ dneg_e;
      negy_f <= vy_e[VW-1] ^ dneg_e;
      dx_f   <= NB'($unsigned(vx_e[VW-1] ? VM'(-vx_e) : VM'(vx_e))) << F;
      dy_f   <= NB'($unsigned(vy_e[VW-1] ? VM'(-vy_e) : VM'(vy_e))) << F;
    end
  end

  assign ctl_o    = '{valid: v_f, rel: rel_f, neg_x: negx_f, neg_y: negy_f};
  assign d_o      = dmag_f;
  assign dvd_o[0] = dx_f;
  assign dvd_o[1] = dy_f;
endmodule

// ===== src/lpi_div_cell.sv =====
// One restoring-division cell: one quotient bit per lane, x and y lanes.
// Depends on lpi_pkg.
`timescale 1ns / 1ps
module lpi_div_cell import lpi_pkg::*; #(
  parameter int NB  = 66,
  parameter int DM  = 33,
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  lpi_ctl_t      ctl_i,
  input  logic [DM-1:0] d_i,
  input  logic [DM-1:0] r_i   [2],
  input  logic [NB-1:0] dvd_i [2],
  input  logic [OUT_BITS-1:0] q_i [2],
  input  logic          stk_i [2],
  output lpi_ctl_t      ctl_o,
  output logic [DM-1:0] d_o,
  output logic [DM-1:0] r_o   [2],
  output logic [NB-1:0] dvd_o [2],
  output logic [OUT_BITS-1:0] q_o [2],
  output logic          stk_o [2]
);
  localparam int  BITPOS = NB - 1 - IDX;
  localparam bit  HIGH   = (BITPOS >= OUT_BITS);

  logic [DM:0]          rs      [2];
  logic                 ge      [2];
  logic [DM-1:0]        r_next  [2];
  logic [OUT_BITS-1:0]  q_next  [2];
  logic                 stk_next[2];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      rs[k]     = {r_i[k], dvd_i[k][NB-1]};
      ge[k]     = rs[k] >= {1'b0, d_i};
      r_next[k] = ge[k] ? DM'(rs[k] - {1'b0, d_i}) : DM'(rs[k]);
      if (HIGH) begin
        q_next[k]   = q_i[k];
        stk_next[k] = stk_i[k] | ge[k];
      end else begin
        q_next[k]   = {q_i[k][OUT_BITS-2:0], ge[k]};
        stk_next[k] = stk_i[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_o <= '0;
    end else if (adv) begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_o <= d_i;
      for (int k = 0; k < 2; k++) begin
        r_o[k]   <= r_next[k];
        dvd_o[k] <= dvd_i[k] << 1;
        q_o[k]   <= q_next[k];
        stk_o[k] <= stk_next[k];
      end
    end
  end
endmodule

// ===== src/lpi_round.sv =====
// Rounding, saturation, sign and output register.
// Depends on lpi_pkg.
`timescale 1ns / 1ps
module lpi_round import lpi_pkg::*; #(
  parameter int DM = 33
) (
  input  logic                       clk,
  input  logic                       rst,
  input  lpi_ctl_t                   ctl_i,
  input  logic [DM-1:0]              d_i,
  input  logic [DM-1:0]              r_i   [2],
  input  logic [OUT_BITS-1:0]        q_i   [2],
  input  logic                       stk_i [2],
  input  logic                       out_ready,
  output logic                       adv,
  output logic                       out_valid,
  output logic [1:0]                 relation,
  output logic signed [OUT_BITS-1:0] cross_x,
  output logic signed [OUT_BITS-1:0] cross_y,
  output logic                       saturated
);
  logic                neg  [2];
  logic                rb   [2];
  logic [OUT_BITS:0]   qr   [2];
  logic [OUT_BITS:0]   lim  [2];
  logic                sat  [2];
  logic [OUT_BITS-1:0] mag  [2];
  logic [OUT_BITS-1:0] val  [2];
  logic                point;

  assign adv   = !out_valid || out_ready;
  assign neg[0] = ctl_i.neg_x;
  assign neg[1] = ctl_i.neg_y;
  assign point = (ctl_i.rel == REL_POINT);

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      rb[k]  = {r_i[k], 1'b0} >= {1'b0, d_i};
      qr[k]  = {1'b0, q_i[k]} + (OUT_BITS + 1)'(rb[k]);
      lim[k] = {1'b0, neg[k], {(OUT_BITS - 1){~neg[k]}}};
      sat[k] = stk_i[k] | (qr[k] > lim[k]);
      mag[k] = sat[k] ? lim[k][OUT_BITS-1:0] : qr[k][OUT_BITS-1:0];
      val[k] = neg[k] ? -mag[k] : mag[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      relation  <= ctl_i.rel;
      cross_x   <= point ? val[0] : '0;
      cross_y   <= point ? val[1] : '0;
      saturated <= point & (sat[0] | sat[1]);
    end
  end
endmodule

// ===== src/line_pair_intersection.sv =====
// Top level: line pair intersection, front pipeline, division cell chain, rounding.
// Depends on lpi_pkg, lpi_front, lpi_div_cell, lpi_round and the assertion macro header.
//
//   channel | handshake            | payload
//   in      | in_valid / in_ready  | a1_x a1_y a2_x a2_y b1_x b1_y b2_x b2_y
//   out     | out_valid / out_ready| relation cross_x cross_y saturated
//
// One transaction per cycle while the output is not stalled. The pipeline has six
// front stages, one division cell per dividend bit and one output register.
// The whole pipeline advances when the output register is empty or being taken;
// in_ready follows that condition. Reset clears all valid bits.
`timescale 1ns / 1ps
`include "line_pair_intersection_defines.svh"
module line_pair_intersection import lpi_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] a1_x,
  input  logic signed [COORD_BITS-1:0] a1_y,
  input  logic signed [COORD_BITS-1:0] a2_x,
  input  logic signed [COORD_BITS-1:0] a2_y,
  input  logic signed [COORD_BITS-1:0] b1_x,
  input  logic signed [COORD_BITS-1:0] b1_y,
  input  logic signed [COORD_BITS-1:0] b2_x,
  input  logic signed [COORD_BITS-1:0] b2_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   relation,
  output logic signed [OUT_BITS-1:0]   cross_x,
  output logic signed [OUT_BITS-1:0]   cross_y,
  output logic                         saturated
);
  localparam int NB = 3 * COORD_BITS + 2 + FRAC_BITS;
  localparam int DM = 2 * COORD_BITS + 1;

  logic                adv;
  lpi_ctl_t            ctl_ch [NB+1];
  logic [DM-1:0]       d_ch   [NB+1];
  logic [DM-1:0]       r_ch   [NB+1][2];
  logic [NB-1:0]       dvd_ch [NB+1][2];
  logic [OUT_BITS-1:0] q_ch   [NB+1][2];
  logic                stk_ch [NB+1][2];

  assign in_ready = adv;

  lpi_front #(.C(COORD_BITS), .F(FRAC_BITS), .NB(NB), .DM(DM)) u_front (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(in_valid),
    .a1_x(a1_x), .a1_y(a1_y), .a2_x(a2_x), .a2_y(a2_y),
    .b1_x(b1_x), .b1_y(b1_y), .b2_x(b2_x), .b2_y(b2_y),
    .ctl_o(ctl_ch[0]), .d_o(d_ch[0]), .dvd_o(dvd_ch[0])
  );

  assign r_ch[0][0]   = '0;
  assign r_ch[0][1]   = '0;
  assign q_ch[0][0]   = '0;
  assign q_ch[0][1]   = '0;
  assign stk_ch[0][0] = 1'b0;
  assign stk_ch[0][1] = 1'b0;

  for (genvar i = 0; i < NB; i++) begin : g_cell
    lpi_div_cell #(.NB(NB), .DM(DM), .IDX(i)) u_cell (
      .clk(clk), .rst(rst), .adv(adv),
      .ctl_i(ctl_ch[i]), .d_i(d_ch[i]), .r_i(r_ch[i]), .dvd_i(dvd_ch[i]),
      .q_i(q_ch[i]), .stk_i(stk_ch[i]),
      .ctl_o(ctl_ch[i+1]), .d_o(d_ch[i+1]), .r_o(r_ch[i+1]), .dvd_o(dvd_ch[i+1]),
      .q_o(q_ch[i+1]), .stk_o(stk_ch[i+1])
    );
  end

  lpi_round #(.DM(DM)) u_round (
    .clk(clk), .rst(rst),
    .ctl_i(ctl_ch[NB]), .d_i(d_ch[NB]), .r_i(r_ch[NB]), .q_i(q_ch[NB]),
    .stk_i(stk_ch[NB]), .out_ready(out_ready), .adv(adv),
    .out_valid(out_valid), .relation(relation), .cross_x(cross_x),
    .cross_y(cross_y), .saturated(saturated)
  );

  `LPI_ASSERT_IMPL(a_nonpoint_zero, out_valid && relation != REL_POINT, cross_x == '0 && cross_y == '0 && !saturated, "non-point result carries a value")
  `LPI_ASSERT_IMPL(a_sat_point, out_valid && saturated, relation == REL_POINT, "saturation on non-point result")
  `LPI_ASSERT_IMPL(a_stall_in, out_valid && !out_ready, !in_ready, "input taken while output stalled")
  `LPI_ASSERT_NEXT(a_hold_out, out_valid && !out_ready, out_valid && $stable(relation) && $stable(cross_x) && $stable(cross_y), "output changed while stalled")
  `LPI_ASSERT_RST(a_reset_empty, !out_valid, "output valid right after reset")
endmodule
